/* src/hpm_pkg.sv */
// Shared types and constants for the Huffman pair-merge scan block.
package hpm_pkg;

   localparam int FREQ_W = 32;
   localparam int GRAY_W = 8;

   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_MERGE = 1'b1;

   localparam logic STATUS_MERGED = 1'b0;
   localparam logic STATUS_SHORT  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH,
      ST_WRITE_LO,
      ST_WRITE_HI,
      ST_RESPOND
   } state_type;

endpackage

/* src/huffman_pair_merge_scan.sv */
// Huffman pair-merge scan: frequency table memory, scan sequencer and result register.
//
// The block keeps a table of TABLE_ENTRIES 32-bit frequencies in a single-port-read,
// single-port-write synchronous memory. A load request writes one entry. A merge
// request reads entries 0 to min(entries_in_use, TABLE_ENTRIES-1), one per cycle
// through the memory read port, tracks the smallest and second-smallest nonzero
// values, then writes the saturated sum to the lower index and zero to the higher
// index in the ST_WRITE_LO and ST_WRITE_HI states. After a merge request is accepted,
// req_stall stays high through the scan, the writes and the response; the one read per
// cycle of the memory sets how often merge requests can follow each other, and a
// previous result still held by rsp_stall stretches the stall further.
// If fewer than two nonzero entries are found the result carries status 1 and the table
// is left untouched. Table entries have no reset value and must be loaded before a merge
// scans them. The result register lets a load request be taken while a merge result
// still waits on rsp_stall.
module huffman_pair_merge_scan
   import hpm_pkg::*;
#(
   parameter int TABLE_ENTRIES = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [GRAY_W-1:0] csr_wr_data,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_action,
   input  logic [GRAY_W-1:0] req_gray_index,
   input  logic [FREQ_W-1:0] req_frequency,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [GRAY_W-1:0] rsp_first_index,
   output logic [GRAY_W-1:0] rsp_second_index,
   output logic [FREQ_W-1:0] rsp_merged_frequency,
   output logic              rsp_status
);

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   logic [FREQ_W-1:0] table_mem [TABLE_ENTRIES];
   logic [FREQ_W-1:0] mem_q_ff;

   state_type state_ff, state_in;
   logic [GRAY_W-1:0] entries_ff;
   logic [IDX_W-1:0]  scan_addr_ff, scan_addr_in;
   logic              issue_ff, issue_in;
   logic              pend_ff, pend_in;
   logic [IDX_W-1:0]  pend_idx_ff, pend_idx_in;
   logic              min_ok_ff, min_ok_in, sec_ok_ff, sec_ok_in;
   logic [FREQ_W-1:0] min_f_ff, min_f_in, sec_f_ff, sec_f_in;
   logic [IDX_W-1:0]  min_i_ff, min_i_in, sec_i_ff, sec_i_in;
   logic [IDX_W-1:0]  res_lo_ff, res_lo_in, res_hi_ff, res_hi_in;
   logic [FREQ_W-1:0] res_sum_ff, res_sum_in;
   logic              res_status_ff, res_status_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [GRAY_W-1:0] rsp_first_ff, rsp_first_in, rsp_second_ff, rsp_second_in;
   logic [FREQ_W-1:0] rsp_sum_ff, rsp_sum_in;
   logic              rsp_status_ff, rsp_status_in;

   logic              rd_en;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [FREQ_W-1:0] wr_data;

   logic              req_take;
   logic              load_in_range;
   logic [31:0]       gray_wide;
   logic [31:0]       last_wide;
   logic [IDX_W-1:0]  last_idx;
   logic [FREQ_W:0]   pair_sum;
   logic [31:0]       lo_wide, hi_wide;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;

   assign gray_wide     = 32'(req_gray_index);
   assign load_in_range = (gray_wide < 32'(TABLE_ENTRIES));

   // The scan stops at the table's last entry even if the register names a higher one.
   assign last_wide = (32'(entries_ff) > 32'(TABLE_ENTRIES - 1)) ?
                      32'(TABLE_ENTRIES - 1) : 32'(entries_ff);
   assign last_idx  = last_wide[IDX_W-1:0];

   assign pair_sum = {1'b0, min_f_ff} + {1'b0, sec_f_ff};
   assign lo_wide  = 32'(res_lo_ff);
   assign hi_wide  = 32'(res_hi_ff);

   always_comb begin
      state_in      = state_ff;
      scan_addr_in  = scan_addr_ff;
      issue_in      = 1'b0;
      pend_in       = 1'b0;
      pend_idx_in   = scan_addr_ff;
      min_ok_in     = min_ok_ff;
      sec_ok_in     = sec_ok_ff;
      min_f_in      = min_f_ff;
      sec_f_in      = sec_f_ff;
      min_i_in      = min_i_ff;
      sec_i_in      = sec_i_ff;
      res_lo_in     = res_lo_ff;
      res_hi_in     = res_hi_ff;
      res_sum_in    = res_sum_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_first_in  = rsp_first_ff;
      rsp_second_in = rsp_second_ff;
      rsp_sum_in    = rsp_sum_ff;
      rsp_status_in = rsp_status_ff;
      rd_en         = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = gray_wide[IDX_W-1:0];
      wr_data       = req_frequency;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_action == ACT_LOAD) begin
                  wr_en = load_in_range;
               end else begin
                  min_ok_in    = 1'b0;
                  sec_ok_in    = 1'b0;
                  scan_addr_in = '0;
                  issue_in     = 1'b1;
                  state_in     = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (issue_ff) begin
               rd_en   = 1'b1;
               pend_in = 1'b1;
               if (scan_addr_ff == last_idx) begin
                  issue_in = 1'b0;
               end else begin
                  issue_in     = 1'b1;
                  scan_addr_in = scan_addr_ff + 1'b1;
               end
            end
            // Zero entries are skipped; equal values keep the earlier index in each role.
            if (pend_ff && (mem_q_ff != '0)) begin
               if (min_ok_ff && (mem_q_ff >= min_f_ff) &&
                   (!sec_ok_ff || (mem_q_ff < sec_f_ff))) begin
                  sec_ok_in = 1'b1;
                  sec_f_in  = mem_q_ff;
                  sec_i_in  = pend_idx_ff;
               end
               if (!min_ok_ff || (mem_q_ff < min_f_ff)) begin
                  sec_ok_in = min_ok_ff;
                  sec_f_in  = min_f_ff;
                  sec_i_in  = min_i_ff;
                  min_ok_in = 1'b1;
                  min_f_in  = mem_q_ff;
                  min_i_in  = pend_idx_ff;
               end
            end
            if (!issue_ff && !pend_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            res_sum_in    = pair_sum[FREQ_W] ? '1 : pair_sum[FREQ_W-1:0];
            res_lo_in     = (min_i_ff < sec_i_ff) ? min_i_ff : sec_i_ff;
            res_hi_in     = (min_i_ff < sec_i_ff) ? sec_i_ff : min_i_ff;
            if (min_ok_ff && sec_ok_ff) begin
               res_status_in = STATUS_MERGED;
               state_in      = ST_WRITE_LO;
            end else begin
               res_status_in = STATUS_SHORT;
               state_in      = ST_RESPOND;
            end
         end
         ST_WRITE_LO: begin
            wr_en    = 1'b1;
            wr_addr  = res_lo_ff;
            wr_data  = res_sum_ff;
            state_in = ST_WRITE_HI;
         end
         ST_WRITE_HI: begin
            wr_en    = 1'b1;
            wr_addr  = res_hi_ff;
            wr_data  = '0;
            state_in = ST_RESPOND;
         end
         ST_RESPOND: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = res_status_ff;
               if (res_status_ff == STATUS_MERGED) begin
                  rsp_first_in  = lo_wide[GRAY_W-1:0];
                  rsp_second_in = hi_wide[GRAY_W-1:0];
                  rsp_sum_in    = res_sum_ff;
               end else begin
                  rsp_first_in  = '0;
                  rsp_second_in = '0;
                  rsp_sum_in    = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         mem_q_ff <= table_mem[scan_addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         entries_ff   <= 8'd255;
         issue_ff     <= 1'b0;
         pend_ff      <= 1'b0;
         min_ok_ff    <= 1'b0;
         sec_ok_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issue_ff     <= issue_in;
         pend_ff      <= pend_in;
         min_ok_ff    <= min_ok_in;
         sec_ok_ff    <= sec_ok_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            entries_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_addr_ff  <= scan_addr_in;
      pend_idx_ff   <= pend_idx_in;
      min_f_ff      <= min_f_in;
      sec_f_ff      <= sec_f_in;
      min_i_ff      <= min_i_in;
      sec_i_ff      <= sec_i_in;
      res_lo_ff     <= res_lo_in;
      res_hi_ff     <= res_hi_in;
      res_sum_ff    <= res_sum_in;
      res_status_ff <= res_status_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_second_ff <= rsp_second_in;
      rsp_sum_ff    <= rsp_sum_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_first_index      = rsp_first_ff;
   assign rsp_second_index     = rsp_second_ff;
   assign rsp_merged_frequency = rsp_sum_ff;
   assign rsp_status           = rsp_status_ff;

endmodule

/* test/tb_huffman_pair_merge_scan.sv */
// Self-checking testbench for the Huffman pair-merge scan block.
module tb_huffman_pair_merge_scan
   import hpm_pkg::*;
();

   localparam int TABLE_DEPTH   = 256;
   // Settle time long enough for a full-table merge to finish; waited before a register write.
   localparam int SETTLE_CYCLES = 300;

   typedef struct packed {
      logic [GRAY_W-1:0] first_index;
      logic [GRAY_W-1:0] second_index;
      logic [FREQ_W-1:0] merged_frequency;
      logic              status;
   } merge_result_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_wr_en = 1'b0;
   logic [GRAY_W-1:0] csr_wr_data = '0;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic              req_action = ACT_LOAD;
   logic [GRAY_W-1:0] req_gray_index = '0;
   logic [FREQ_W-1:0] req_frequency = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [GRAY_W-1:0] rsp_first_index;
   logic [GRAY_W-1:0] rsp_second_index;
   logic [FREQ_W-1:0] rsp_merged_frequency;
   logic              rsp_status;

   logic [FREQ_W-1:0] freq_table [TABLE_DEPTH];
   logic [GRAY_W-1:0] scan_last = 8'd255;
   merge_result_type  expected_merges [$];

   int tx_idle_pct = 20;
   int rx_idle_pct = 20;
   int hold_cycles = 0;
   int items_sent = 0;
   int error_count = 0;

   huffman_pair_merge_scan dut (
      .clock                (clock),
      .reset                (reset),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_action           (req_action),
      .req_gray_index       (req_gray_index),
      .req_frequency        (req_frequency),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_first_index      (rsp_first_index),
      .rsp_second_index     (rsp_second_index),
      .rsp_merged_frequency (rsp_merged_frequency),
      .rsp_status           (rsp_status)
   );

   always #5 clock = ~clock;

   // Scans the window, picks the two smallest nonzero counts and folds them together.
   function automatic merge_result_type predict_merge();
      merge_result_type  res;
      bit                have_min;
      bit                have_sec;
      logic [FREQ_W-1:0] min_f;
      logic [FREQ_W-1:0] sec_f;
      logic [FREQ_W-1:0] f;
      int                min_i;
      int                sec_i;
      int                lo;
      int                hi;
      logic [FREQ_W:0]   total;
      have_min = 1'b0;
      have_sec = 1'b0;
      min_f = '0;
      sec_f = '0;
      min_i = 0;
      sec_i = 0;
      for (int i = 0; i <= int'(scan_last); i++) begin
         f = freq_table[i];
         if (f != '0) begin
            if (have_min && f >= min_f && (!have_sec || f < sec_f)) begin
               have_sec = 1'b1;
               sec_f = f;
               sec_i = i;
            end
            if (!have_min || f < min_f) begin
               have_sec = have_min;
               sec_f = min_f;
               sec_i = min_i;
               have_min = 1'b1;
               min_f = f;
               min_i = i;
            end
         end
      end
      if (!have_min || !have_sec) begin
         res = '{first_index: '0, second_index: '0, merged_frequency: '0,
                 status: STATUS_SHORT};
         return res;
      end
      lo = (min_i < sec_i) ? min_i : sec_i;
      hi = (min_i < sec_i) ? sec_i : min_i;
      total = {1'b0, min_f} + {1'b0, sec_f};
      if (total[FREQ_W])
         total = {1'b0, {FREQ_W{1'b1}}};
      freq_table[lo] = total[FREQ_W-1:0];
      freq_table[hi] = '0;
      res = '{first_index: GRAY_W'(lo), second_index: GRAY_W'(hi),
              merged_frequency: total[FREQ_W-1:0], status: STATUS_MERGED};
      return res;
   endfunction

   // Small values provoke ties, values near the top provoke saturation.
   function automatic logic [FREQ_W-1:0] rand_freq();
      case ($urandom_range(0, 3))
         0: return FREQ_W'($urandom_range(1, 6));
         1: return FREQ_W'($urandom_range(1, 1000));
         2: return {FREQ_W{1'b1}} - FREQ_W'($urandom_range(0, 15));
         default: return $urandom();
      endcase
   endfunction

   // Offers one request and returns at the edge that accepts it, leaving valid high.
   task automatic send_request(input logic action, input logic [GRAY_W-1:0] index,
                               input logic [FREQ_W-1:0] freq);
      if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_action     <= action;
      req_gray_index <= index;
      req_frequency  <= freq;
      do @(posedge clock); while (req_stall);
      items_sent++;
      if (action == ACT_MERGE)
         expected_merges.push_back(predict_merge());
      else
         freq_table[index] = freq;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_merges.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_entries_in_use(input logic [GRAY_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      scan_last = value;
   endtask

   // Loads followed by merge steps inside the current window, with some stray requests.
   task automatic run_merge_rounds(input int budget);
      int stop_at;
      int merges;
      int merge_cap;
      int k;
      stop_at = items_sent + budget;
      merges = 0;
      merge_cap = (scan_last > 31) ? 4 : budget;
      while (items_sent < stop_at) begin
         if ($urandom_range(0, 99) < 15) begin
            if ($urandom_range(0, 1) == 0 || merges >= merge_cap) begin
               send_request(ACT_LOAD, GRAY_W'($urandom_range(0, 255)), $urandom());
            end else begin
               send_request(ACT_MERGE, GRAY_W'($urandom()), $urandom());
               merges++;
            end
         end else begin
            k = $urandom_range(1, (scan_last < 7) ? int'(scan_last) + 1 : 8);
            repeat (k)
               send_request(ACT_LOAD, GRAY_W'($urandom_range(0, scan_last)),
                            ($urandom_range(0, 9) == 0) ? '0 : rand_freq());
            repeat ($urandom_range(1, k + 1)) begin
               if (merges < merge_cap) begin
                  send_request(ACT_MERGE, GRAY_W'($urandom()), $urandom());
                  merges++;
               end
            end
         end
      end
   endtask

   // Every entry is written once so that no merge ever reads an unwritten entry.
   task automatic load_whole_table();
      for (int i = 0; i < TABLE_DEPTH; i++)
         send_request(ACT_LOAD, GRAY_W'(i),
                      ($urandom_range(0, 9) < 4) ? '0 : rand_freq());
   endtask

   task automatic test_tie_rules();
      wait_drained();
      write_entries_in_use(8'd3);
      send_request(ACT_LOAD, 8'd0, 32'd5);
      send_request(ACT_LOAD, 8'd1, 32'd5);
      send_request(ACT_LOAD, 8'd2, 32'd5);
      send_request(ACT_LOAD, 8'd3, 32'd0);
      repeat (3) send_request(ACT_MERGE, GRAY_W'($urandom()), $urandom());
      // A repeated minimum later in the scan takes over the second role.
      send_request(ACT_LOAD, 8'd0, 32'd4);
      send_request(ACT_LOAD, 8'd1, 32'd2);
      send_request(ACT_LOAD, 8'd2, 32'd4);
      send_request(ACT_LOAD, 8'd3, 32'd2);
      send_request(ACT_MERGE, 8'hFF, 32'hFFFF_FFFF);
   endtask

   task automatic test_saturation();
      send_request(ACT_LOAD, 8'd0, 32'hFFFF_FFFF);
      send_request(ACT_LOAD, 8'd1, 32'd0);
      send_request(ACT_LOAD, 8'd2, 32'd1);
      send_request(ACT_LOAD, 8'd3, 32'hFFFF_FFFF);
      send_request(ACT_MERGE, 8'd0, 32'd0);
   endtask

   task automatic test_fewer_than_two();
      for (int i = 0; i < 4; i++)
         send_request(ACT_LOAD, GRAY_W'(i), '0);
      send_request(ACT_MERGE, GRAY_W'($urandom()), $urandom());
      send_request(ACT_LOAD, 8'd2, 32'd77);
      send_request(ACT_MERGE, GRAY_W'($urandom()), $urandom());
   endtask

   task automatic test_window_extremes();
      wait_drained();
      write_entries_in_use(8'd0);
      send_request(ACT_MERGE, GRAY_W'($urandom()), $urandom());
      wait_drained();
      write_entries_in_use(8'd255);
      repeat (2) send_request(ACT_MERGE, GRAY_W'($urandom()), $urandom());
      wait_drained();
      write_entries_in_use(8'd1);
      send_request(ACT_LOAD, 8'd0, 32'd9);
      send_request(ACT_LOAD, 8'd1, 32'd9);
      send_request(ACT_MERGE, GRAY_W'($urandom()), $urandom());
   endtask

   // The receiver holds off while merges keep coming, so the block must stall its input.
   task automatic test_result_backpressure();
      wait_drained();
      write_entries_in_use(8'd5);
      for (int i = 0; i < 6; i++)
         send_request(ACT_LOAD, GRAY_W'(i), rand_freq());
      hold_cycles = 400;
      repeat (10) begin
         send_request(ACT_MERGE, GRAY_W'($urandom()), $urandom());
         send_request(ACT_LOAD, GRAY_W'($urandom_range(0, 5)), rand_freq());
      end
      wait_drained();
   endtask

   task automatic test_random_sequences(input int items_goal);
      logic [GRAY_W-1:0] window;
      while (items_sent < items_goal) begin
         wait_drained();
         case ($urandom_range(0, 11))
            0: window = GRAY_W'($urandom_range(16, 255));
            1: window = 8'd1;
            default: window = GRAY_W'($urandom_range(2, 15));
         endcase
         write_entries_in_use(window);
         tx_idle_pct = 15 * $urandom_range(0, 2);
         rx_idle_pct = 15 * $urandom_range(0, 2);
         run_merge_rounds($urandom_range(60, 140));
      end
   endtask

   task automatic test_steady_tail();
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      wait_drained();
      write_entries_in_use(GRAY_W'($urandom_range(2, 12)));
      run_merge_rounds(120);
   endtask

   initial begin
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
            rsp_stall <= 1'b0;
         end else if (rx_idle_pct > 0 && $urandom_range(0, 99) < rx_idle_pct) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 17)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      merge_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_merges.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result first=%0d second=%0d sum=%h status=%0b",
                     $time, rsp_first_index, rsp_second_index, rsp_merged_frequency,
                     rsp_status);
         end else begin
            want = expected_merges.pop_front();
            if (rsp_first_index !== want.first_index
                || rsp_second_index !== want.second_index
                || rsp_merged_frequency !== want.merged_frequency
                || rsp_status !== want.status) begin
               error_count++;
               $display("%0t: expected first=%0d second=%0d sum=%h status=%0b,",
                        $time, want.first_index, want.second_index,
                        want.merged_frequency, want.status,
                        " actual first=%0d second=%0d sum=%h status=%0b",
                        rsp_first_index, rsp_second_index, rsp_merged_frequency,
                        rsp_status);
            end
         end
      end
   end

   initial begin
      #50_000_000;
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      load_whole_table();
      test_tie_rules();
      test_saturation();
      test_fewer_than_two();
      test_window_extremes();
      test_result_backpressure();
      test_random_sequences(1380);
      test_steady_tail();
      wait_drained();
      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
